// ----- rtl/core/ciqs_pkg.sv -----
// Shared types, constants and table generation functions of the chirp I/Q synthesizer.
package ciqs_pkg;

	localparam int unsigned BESSEL_TABLE_DEPTH_DEF = 1024;
	localparam int unsigned COS_TABLE_DEPTH_DEF    = 1024;
	localparam int unsigned QUEUE_DEPTH            = 2;
	localparam int unsigned REG_INDEX_W            = 3;

	localparam logic [31:0] PITCH_GAIN_ONE = 32'h0100_0000;
	localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

	localparam longint      ONE_Q30           = 64'sd1073741824;
	localparam logic [63:0] HALF_PI_Q30       = 64'd1686629713;
	localparam logic [63:0] TURNS_PER_RAD_Q32 = 64'd683565276;
	localparam logic [63:0] MASK32            = 64'h0000_0000_FFFF_FFFF;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_START_PHASE      = 3'd0,
		REG_LO_PHASE_STEP    = 3'd1,
		REG_START_FREQ_STEP  = 3'd2,
		REG_CHIRP_STEP       = 3'd3,
		REG_PITCH_GAIN       = 3'd4,
		REG_AMPLITUDE_SCALE  = 3'd5,
		REG_BESSEL_ARG_SCALE = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic               start_req;
		logic signed [31:0] sample_i_in;
		logic signed [31:0] sample_q_in;
	} ciqs_in_t;

	typedef struct packed {
		logic signed [31:0] sample_i_out;
		logic signed [31:0] sample_q_out;
		logic               saturated;
	} ciqs_out_t;

	typedef struct packed {
		logic [31:0]        start_phase;
		logic [31:0]        lo_phase_step;
		logic [31:0]        start_freq_step;
		logic signed [31:0] chirp_step;
		logic [31:0]        pitch_gain;
		logic [15:0]        amplitude_scale;
		logic [31:0]        bessel_arg_scale;
	} ciqs_cfg_t;

	typedef struct packed {
		logic               start_req;
		logic [31:0]        freq_step;
		logic [31:0]        osc_phase;
		logic signed [31:0] sample_i;
		logic signed [31:0] sample_q;
	} ciqs_work_t;

	// Taylor term divisor (2n-1)*2n
	function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
		case (n)
			1:       return v / 64'd2;
			2:       return v / 64'd12;
			3:       return v / 64'd30;
			4:       return v / 64'd56;
			5:       return v / 64'd90;
			6:       return v / 64'd132;
			7:       return v / 64'd182;
			8:       return v / 64'd240;
			9:       return v / 64'd306;
			default: return v / 64'd380;
		endcase
	endfunction

	// cosine over one quadrant, u in quarter turns Q30, result Q30
	function automatic longint quarter_cos(input logic [63:0] u);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x    = (u * HALF_PI_Q30) >> 30;
		x2   = (x * x) >> 30;
		term = 64'(ONE_Q30);
		sum  = ONE_Q30;
		for (int n = 1; n <= 10; n++) begin
			term = taylor_div((term * x2) >> 30, n);
			if (n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		return sum;
	endfunction

	// cosine of a phase in turns/2^32, Q2.30
	function automatic logic signed [31:0] fine_cos(input logic [31:0] p);
		logic [63:0] r;
		logic [63:0] rc;
		longint      v;
		r  = {34'd0, p[29:0]};
		rc = 64'(ONE_Q30) - r;
		case (p[31:30])
			2'd0:    v = quarter_cos(r);
			2'd1:    v = -quarter_cos(rc);
			2'd2:    v = -quarter_cos(r);
			default: v = quarter_cos(rc);
		endcase
		return 32'(v);
	endfunction

	// j0 by a 64 point trapezoid mean, x in Q26 rad
	function automatic logic signed [31:0] bessel_entry(input logic [63:0] x);
		longint      sum;
		longint      s;
		logic [63:0] amag;
		logic [63:0] a;
		logic [63:0] ph;
		logic [63:0] biased;
		sum = 0;
		for (int m = 0; m < 64; m++) begin
			s    = longint'(fine_cos(32'((64'(m) << 26) - 64'(ONE_Q30))));
			amag = (s < 0) ? 64'(-s) : 64'(s);
			a    = (x * amag) >> 30;
			ph   = ((a * TURNS_PER_RAD_Q32) >> 26) & MASK32;
			sum  = sum + longint'(fine_cos(ph[31:0]));
		end
		biased = 64'(sum + 64 * ONE_Q30);
		return 32'(longint'((biased + 64'd32) >> 6) - ONE_Q30);
	endfunction

endpackage

// ----- rtl/core/chirp_iq_synthesizer_unit.sv -----
// Top level of the chirp I/Q synthesizer: front end, work queue, back end, result queue.
// Each input beat adds one sample of a linear chirp, mixed against a local oscillator and
// weighted by a j0 amplitude, into the incoming I/Q pair and returns one result beat.
// The front end takes a beat in any cycle in which full is low and queues it with the
// LO phase and ramped frequency step; the back end then works one beat at a time
// through a sequence on a single shared 32x32 multiplier, and a two-entry result queue
// decouples it from pop.
// The cosine and j0 tables are built at elaboration; no clearing pass follows reset.
// Write configuration only while no beat is in flight.
module chirp_iq_synthesizer_unit #(
	parameter int unsigned BESSEL_TABLE_DEPTH = ciqs_pkg::BESSEL_TABLE_DEPTH_DEF,
	parameter int unsigned COS_TABLE_DEPTH    = ciqs_pkg::COS_TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [ciqs_pkg::REG_INDEX_W-1:0] wr_index,
	input  logic [31:0]                      wr_data,
	input  logic                             push,
	output logic                             full,
	input  ciqs_pkg::ciqs_in_t               item,
	input  logic                             pop,
	output logic                             empty,
	output ciqs_pkg::ciqs_out_t              result
);

	ciqs_pkg::ciqs_cfg_t  cfg;
	ciqs_pkg::ciqs_work_t work_in;
	ciqs_pkg::ciqs_work_t work_out;
	ciqs_pkg::ciqs_out_t  res_in;
	logic                 take;
	logic                 work_empty;
	logic                 work_pop;
	logic                 res_full;
	logic                 res_push;

	assign take = push && !full;

	ciqs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.take     (take),
		.item     (item),
		.cfg      (cfg),
		.work     (work_in)
	);

	ciqs_fifo #(
		.Width ($bits(ciqs_pkg::ciqs_work_t)),
		.Depth (ciqs_pkg::QUEUE_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wdata  (work_in),
		.full   (full),
		.rd     (work_pop),
		.rdata  (work_out),
		.empty  (work_empty)
	);

	ciqs_back #(
		.BESSEL_TABLE_DEPTH (BESSEL_TABLE_DEPTH),
		.COS_TABLE_DEPTH    (COS_TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.work        (work_out),
		.work_empty  (work_empty),
		.work_pop    (work_pop),
		.result      (res_in),
		.result_full (res_full),
		.result_push (res_push)
	);

	ciqs_fifo #(
		.Width ($bits(ciqs_pkg::ciqs_out_t)),
		.Depth (ciqs_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// ----- rtl/core/ciqs_fifo.sv -----
// Small first-in first-out queue with full and empty flags.
module ciqs_fifo #(
	parameter int unsigned Width = 1,
	parameter int unsigned Depth = ciqs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [Width-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = $clog2(Depth);
	localparam int unsigned CW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(Depth));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/ciqs_front.sv -----
// Front end: configuration registers, LO phase and frequency ramp per accepted beat.
module ciqs_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [ciqs_pkg::REG_INDEX_W-1:0]      wr_index,
	input  logic [31:0]                           wr_data,
	input  logic                                  take,
	input  ciqs_pkg::ciqs_in_t                    item,
	output ciqs_pkg::ciqs_cfg_t                   cfg,
	output ciqs_pkg::ciqs_work_t                  work
);

	ciqs_pkg::ciqs_cfg_t cfg_q;
	logic [31:0]         osc_phase_q;
	logic [31:0]         freq_q;
	logic [31:0]         base_lo;
	logic [31:0]         base_freq;
	logic [33:0]         freq_sum;
	logic [31:0]         freq_next;
	logic [31:0]         lo_next;

	assign cfg = cfg_q;

	always_comb begin
		base_lo   = item.start_req ? 32'd0 : osc_phase_q;
		base_freq = item.start_req ? cfg_q.start_freq_step : freq_q;
		lo_next   = base_lo + cfg_q.lo_phase_step;
		freq_sum  = {2'b00, base_freq} + {{2{cfg_q.chirp_step[31]}}, cfg_q.chirp_step};
		if (freq_sum[33]) begin
			freq_next = '0;
		end else if (freq_sum[32]) begin
			freq_next = '1;
		end else begin
			freq_next = freq_sum[31:0];
		end
		work.start_req = item.start_req;
		work.freq_step = freq_next;
		work.osc_phase = lo_next;
		work.sample_i  = item.sample_i_in;
		work.sample_q  = item.sample_q_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_phase      <= '0;
			cfg_q.lo_phase_step    <= '0;
			cfg_q.start_freq_step  <= '0;
			cfg_q.chirp_step       <= '0;
			cfg_q.pitch_gain       <= ciqs_pkg::PITCH_GAIN_ONE;
			cfg_q.amplitude_scale  <= '0;
			cfg_q.bessel_arg_scale <= '0;
		end else if (wr_en) begin
			case (wr_index)
				ciqs_pkg::REG_START_PHASE:      cfg_q.start_phase      <= wr_data;
				ciqs_pkg::REG_LO_PHASE_STEP:    cfg_q.lo_phase_step    <= wr_data;
				ciqs_pkg::REG_START_FREQ_STEP:  cfg_q.start_freq_step  <= wr_data;
				ciqs_pkg::REG_CHIRP_STEP:       cfg_q.chirp_step       <= wr_data;
				ciqs_pkg::REG_PITCH_GAIN:       cfg_q.pitch_gain       <= wr_data;
				ciqs_pkg::REG_AMPLITUDE_SCALE:  cfg_q.amplitude_scale  <= wr_data[15:0];
				ciqs_pkg::REG_BESSEL_ARG_SCALE: cfg_q.bessel_arg_scale <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_phase_q <= '0;
			freq_q      <= '0;
		end else if (take) begin
			osc_phase_q <= lo_next;
			freq_q      <= freq_next;
		end
	end

endmodule

// ----- rtl/core/ciqs_back.sv -----
// Back end: signal phase, j0 amplitude, cos/sin lookup, mixing and saturation.
module ciqs_back #(
	parameter int unsigned BESSEL_TABLE_DEPTH = ciqs_pkg::BESSEL_TABLE_DEPTH_DEF,
	parameter int unsigned COS_TABLE_DEPTH    = ciqs_pkg::COS_TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ciqs_pkg::ciqs_cfg_t   cfg,
	input  ciqs_pkg::ciqs_work_t  work,
	input  logic                  work_empty,
	output logic                  work_pop,
	output ciqs_pkg::ciqs_out_t   result,
	input  logic                  result_full,
	output logic                  result_push
);

	localparam int unsigned JAW = $clog2(BESSEL_TABLE_DEPTH);
	localparam int unsigned CAW = $clog2(COS_TABLE_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PITCH, ST_BARG, ST_JIDX, ST_CIDX, ST_SIDX, ST_AMP,
		ST_AMPR, ST_MCOS, ST_MSIN, ST_SINP, ST_FIN, ST_DONE
	} state_t;

	logic signed [31:0] cos_rom [COS_TABLE_DEPTH];
	logic signed [31:0] j0_rom  [BESSEL_TABLE_DEPTH];

	for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_cos
		localparam logic [63:0]        PA = (64'(k) << 32) / COS_TABLE_DEPTH;
		localparam logic signed [31:0] CV = ciqs_pkg::fine_cos(PA[31:0]);
		assign cos_rom[k] = CV;
	end

	for (genvar k = 0; k < BESSEL_TABLE_DEPTH; k++) begin : g_j0
		localparam logic [63:0]        XA = (64'(k) << 31) / BESSEL_TABLE_DEPTH;
		localparam logic signed [31:0] JV = ciqs_pkg::bessel_entry(XA);
		assign j0_rom[k] = JV;
	end

	state_t             state_q;
	logic [31:0]        freq_q;
	logic [31:0]        lo_q;
	logic signed [31:0] smp_i_q;
	logic signed [31:0] smp_q_q;
	logic [31:0]        phase_q;
	logic [31:0]        d_q;
	logic [63:0]        prod_q;
	logic [JAW-1:0]     jaddr_q;
	logic [CAW-1:0]     caddr_q;
	logic signed [31:0] jdat_q;
	logic signed [31:0] cdat_q;
	logic [31:0]        amp_q;
	logic               amp_neg_q;
	logic signed [31:0] cos_q;
	logic signed [17:0] ci_q;
	logic signed [17:0] cq_q;
	logic signed [31:0] res_i_q;
	logic signed [31:0] res_q_q;
	logic               clip_i_q;
	logic               sat_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] t_sat;
	logic [31:0] jmag;
	logic [31:0] cos_mag;
	logic [31:0] sin_mag;
	logic [46:0] amp_rnd;
	logic [32:0] sum_i;
	logic [32:0] sum_q;

	function automatic logic signed [17:0] round_term(input logic [63:0] p, input logic neg);
		logic [63:0] rnd;
		logic [17:0] mag;
		rnd = p + 64'h0000_2000_0000_0000;
		mag = {1'b0, rnd[62:46]};
		return neg ? -mag : mag;
	endfunction

	function automatic logic [32:0] sat_add(input logic signed [31:0] a,
		input logic signed [17:0] b);
		logic [32:0] s;
		s = {a[31], a} + {{15{b[17]}}, b};
		if (s[32] != s[31]) begin
			return {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
		end
		return {1'b0, s[31:0]};
	endfunction

	always_comb begin
		t_sat   = (prod_q[63:56] != 8'd0) ? '1 : prod_q[55:24];
		jmag    = jdat_q[31] ? (~jdat_q + 32'd1) : jdat_q;
		cos_mag = cos_q[31] ? (~cos_q + 32'd1) : cos_q;
		sin_mag = cdat_q[31] ? (~cdat_q + 32'd1) : cdat_q;
		amp_rnd = {1'b0, prod_q[45:0]} + 47'd8192;
		sum_i   = sat_add(smp_i_q, ci_q);
		sum_q   = sat_add(smp_q_q, cq_q);
		case (state_q)
			ST_PITCH: begin mul_a = freq_q; mul_b = cfg.pitch_gain; end
			ST_BARG:  begin mul_a = freq_q; mul_b = cfg.bessel_arg_scale; end
			ST_JIDX:  begin mul_a = t_sat; mul_b = 32'(BESSEL_TABLE_DEPTH); end
			ST_CIDX:  begin mul_a = d_q; mul_b = 32'(COS_TABLE_DEPTH); end
			ST_SIDX:  begin
				mul_a = d_q - ciqs_pkg::QUARTER_TURN;
				mul_b = 32'(COS_TABLE_DEPTH);
			end
			ST_AMP:   begin mul_a = {16'd0, cfg.amplitude_scale}; mul_b = jmag; end
			ST_MCOS:  begin mul_a = amp_q; mul_b = cos_mag; end
			ST_MSIN:  begin mul_a = amp_q; mul_b = sin_mag; end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign work_pop            = (state_q == ST_IDLE) && !work_empty;
	assign result_push         = (state_q == ST_DONE) && !result_full;
	assign result.sample_i_out = res_i_q;
	assign result.sample_q_out = res_q_q;
	assign result.saturated    = sat_q;

	always_ff @(posedge clk) begin
		jdat_q <= j0_rom[jaddr_q];
		cdat_q <= cos_rom[caddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			freq_q    <= '0;
			lo_q      <= '0;
			smp_i_q   <= '0;
			smp_q_q   <= '0;
			d_q       <= '0;
			prod_q    <= '0;
			jaddr_q   <= '0;
			caddr_q   <= '0;
			amp_q     <= '0;
			amp_neg_q <= 1'b0;
			cos_q     <= '0;
			ci_q      <= '0;
			cq_q      <= '0;
			res_i_q   <= '0;
			res_q_q   <= '0;
			clip_i_q  <= 1'b0;
			sat_q     <= 1'b0;
		end else begin
			prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
			case (state_q)
				ST_IDLE: begin
					if (!work_empty) begin
						freq_q  <= work.freq_step;
						lo_q    <= work.osc_phase;
						smp_i_q <= work.sample_i;
						smp_q_q <= work.sample_q;
						if (work.start_req) begin
							phase_q <= cfg.start_phase;
						end
						state_q <= ST_PITCH;
					end
				end
				ST_PITCH: state_q <= ST_BARG;
				ST_BARG: begin
					phase_q <= phase_q + prod_q[55:24];
					state_q <= ST_JIDX;
				end
				ST_JIDX: begin
					d_q     <= phase_q - lo_q;
					state_q <= ST_CIDX;
				end
				ST_CIDX: begin
					jaddr_q <= prod_q[32 +: JAW];
					state_q <= ST_SIDX;
				end
				ST_SIDX: begin
					caddr_q <= prod_q[32 +: CAW];
					state_q <= ST_AMP;
				end
				ST_AMP: begin
					caddr_q <= prod_q[32 +: CAW];
					state_q <= ST_AMPR;
				end
				ST_AMPR: begin
					amp_q     <= amp_rnd[45:14];
					amp_neg_q <= jdat_q[31];
					cos_q     <= cdat_q;
					state_q   <= ST_MCOS;
				end
				ST_MCOS: state_q <= ST_MSIN;
				ST_MSIN: begin
					ci_q    <= round_term(prod_q, amp_neg_q ^ cos_q[31]);
					state_q <= ST_SINP;
				end
				ST_SINP: begin
					cq_q     <= round_term(prod_q, amp_neg_q ^ cdat_q[31]);
					res_i_q  <= sum_i[31:0];
					clip_i_q <= sum_i[32];
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					res_q_q <= sum_q[31:0];
					sat_q   <= clip_i_q | sum_q[32];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!result_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/ciqs_checker.sv -----
// Port-level checks of beat accounting for the chirp I/Q synthesizer, bound to the top level.
module ciqs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             push,
	input logic                             full,
	input logic                             pop,
	input logic                             empty,
	input ciqs_pkg::ciqs_out_t              result
);

	localparam int unsigned Capacity = 2 * ciqs_pkg::QUEUE_DEPTH + 1;
	localparam int unsigned OW       = $clog2(Capacity + 1);

	logic [OW-1:0] pending_q;
	logic          in_beat;
	logic          out_beat;

	assign in_beat  = push && !full;
	assign out_beat = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result beat changed while waiting");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (pending_q != '0))
		else $error("result beat without an accepted input beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OW'(Capacity))
		else $error("more beats in flight than the queues hold");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == '0) |-> empty)
		else $error("result shown with no beat in flight");

endmodule

bind chirp_iq_synthesizer_unit ciqs_checker u_ciqs_checker (.*);

// ----- tb/tb_chirp_iq_synthesizer_unit.sv -----
// Self-checking testbench of the chirp I/Q synthesizer unit, with a bit-exact predictor.
module tb_chirp_iq_synthesizer_unit;
	import ciqs_pkg::*;

	localparam int unsigned J0_DEPTH    = 1024;
	localparam int unsigned COS_DEPTH   = 1024;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RUN_PHASES  = 8;
	localparam int unsigned PHASE_BEATS = 167;
	localparam int unsigned PLAN_ROWS   = 26;
	localparam int unsigned HOLD_CYCLES = 300;

	localparam logic [2:0]  REG_UNUSED   = 3'd7;
	localparam logic [31:0] UNITY_GAIN   = 32'h0100_0000;
	localparam logic [31:0] QTURN        = 32'h4000_0000;
	localparam longint      UNIT_Q30     = 64'sd1073741824;
	localparam logic [63:0] HALF_PI_FIX  = 64'd1686629713;
	localparam logic [63:0] TURN_PER_RAD = 64'd683565276;
	localparam logic [63:0] WORD_MAX     = 64'h0000_0000_FFFF_FFFF;
	localparam longint      I32_MAX      = 64'sd2147483647;
	localparam longint      I32_MIN      = -64'sd2147483648;

	typedef struct packed {
		logic       is_cfg;
		logic [2:0] idx;
		logic [31:0] data;
		ciqs_in_t   beat;
		logic       lit;
		ciqs_out_t  want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [REG_INDEX_W-1:0] wr_index;
	logic [31:0]            wr_data;
	logic                   push;
	logic                   full;
	ciqs_in_t               item;
	logic                   pop;
	logic                   empty;
	ciqs_out_t              result;

	ciqs_cfg_t   cfg_now;
	logic [31:0] lo_acc;
	logic [31:0] freq_acc;
	logic [31:0] sig_acc;
	longint      cos_tab [COS_DEPTH];
	longint      j0_tab [J0_DEPTH];
	ciqs_out_t   iq_due [$];
	plan_row_t   plan [PLAN_ROWS];
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;
	bit          push_on = 0;
	bit          wr_on = 0;
	bit          steady = 0;
	bit          stall_req = 0;

	chirp_iq_synthesizer_unit #(
		.BESSEL_TABLE_DEPTH(J0_DEPTH),
		.COS_TABLE_DEPTH(COS_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint quad_cos(input logic [63:0] u);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      acc;
		x    = (u * HALF_PI_FIX) >> 30;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		acc  = UNIT_Q30;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > UNIT_Q30) begin
			acc = UNIT_Q30;
		end
		return acc;
	endfunction

	function automatic longint turn_cos(input logic [31:0] p);
		logic [63:0] frac;
		frac = {34'd0, p[29:0]};
		case (p[31:30])
			2'd0:    return quad_cos(frac);
			2'd1:    return -quad_cos(64'(UNIT_Q30) - frac);
			2'd2:    return -quad_cos(frac);
			default: return quad_cos(64'(UNIT_Q30) - frac);
		endcase
	endfunction

	// round(a*b / 2^sh), halves away from zero
	function automatic longint rnd_mul(input longint a, input longint b, input int sh);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] r;
		bit          neg;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? 64'(-a) : 64'(a);
		ub  = (b < 0) ? 64'(-b) : 64'(b);
		r   = (ua * ub + (64'd1 << (sh - 1))) >> sh;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic int unsigned trig_index(input logic [31:0] p);
		return int'(({32'd0, p} * COS_DEPTH) >> 32);
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			REG_START_PHASE:      cfg_now.start_phase      = data;
			REG_LO_PHASE_STEP:    cfg_now.lo_phase_step    = data;
			REG_START_FREQ_STEP:  cfg_now.start_freq_step  = data;
			REG_CHIRP_STEP:       cfg_now.chirp_step       = data;
			REG_PITCH_GAIN:       cfg_now.pitch_gain       = data;
			REG_AMPLITUDE_SCALE:  cfg_now.amplitude_scale  = data[15:0];
			REG_BESSEL_ARG_SCALE: cfg_now.bessel_arg_scale = data;
			default: ;
		endcase
	endfunction

	// advances the chirp state by one sample and returns the mixed, saturated I/Q pair
	function automatic ciqs_out_t mix_sample(input ciqs_in_t b);
		longint      f;
		longint      amp;
		longint      ci;
		longint      cq;
		longint      si;
		longint      sq;
		logic [63:0] prod;
		logic [63:0] t;
		logic [31:0] d;
		int unsigned k;
		ciqs_out_t   o;
		if (b.start_req) begin
			lo_acc   = '0;
			sig_acc  = cfg_now.start_phase;
			freq_acc = cfg_now.start_freq_step;
		end
		lo_acc = lo_acc + cfg_now.lo_phase_step;
		f = longint'({32'd0, freq_acc}) +
			longint'({{32{cfg_now.chirp_step[31]}}, cfg_now.chirp_step});
		if (f < 0) begin
			f = 0;
		end else if (f > longint'(WORD_MAX)) begin
			f = longint'(WORD_MAX);
		end
		freq_acc = f[31:0];
		prod     = {32'd0, freq_acc} * {32'd0, cfg_now.pitch_gain};
		sig_acc  = sig_acc + prod[55:24];
		t = ({32'd0, freq_acc} * {32'd0, cfg_now.bessel_arg_scale}) >> 24;
		if (t > WORD_MAX) begin
			t = WORD_MAX;
		end
		k   = int'((t * J0_DEPTH) >> 32);
		amp = rnd_mul(longint'({48'd0, cfg_now.amplitude_scale}), j0_tab[k], 14);
		d   = sig_acc - lo_acc;
		ci  = rnd_mul(amp, cos_tab[trig_index(d)], 46);
		cq  = rnd_mul(amp, cos_tab[trig_index(d - QTURN)], 46);
		si  = longint'($signed(b.sample_i_in)) + ci;
		sq  = longint'($signed(b.sample_q_in)) + cq;
		o.saturated = 1'b0;
		if (si > I32_MAX) begin
			si = I32_MAX;
			o.saturated = 1'b1;
		end else if (si < I32_MIN) begin
			si = I32_MIN;
			o.saturated = 1'b1;
		end
		if (sq > I32_MAX) begin
			sq = I32_MAX;
			o.saturated = 1'b1;
		end else if (sq < I32_MIN) begin
			sq = I32_MIN;
			o.saturated = 1'b1;
		end
		o.sample_i_out = si[31:0];
		o.sample_q_out = sq[31:0];
		return o;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4, 5:    return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_level();
		case ($urandom_range(9))
			0:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 70000));
			1:       return 32'h8000_0000 + 32'($urandom_range(0, 70000));
			2:       return 32'($urandom_range(0, 511)) - 32'd256;
			default: return $urandom;
		endcase
	endfunction

	function automatic plan_row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
		plan_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic plan_row_t beat_row(input logic st, input logic [31:0] i,
		input logic [31:0] q);
		plan_row_t r;
		r                  = '0;
		r.beat.start_req   = st;
		r.beat.sample_i_in = i;
		r.beat.sample_q_in = q;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic st, input logic [31:0] i,
		input logic [31:0] q, input logic [31:0] oi, input logic [31:0] oq, input logic sat);
		plan_row_t r;
		r                   = beat_row(st, i, q);
		r.lit               = 1'b1;
		r.want.sample_i_out = oi;
		r.want.sample_q_out = oq;
		r.want.saturated    = sat;
		return r;
	endfunction

	task automatic drop_push();
		if (push_on) begin
			push <= 1'b0;
			push_on = 0;
		end
	endtask

	task automatic maybe_idle();
		if (!steady && $urandom_range(99) < 15) begin
			drop_push();
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		drop_push();
		while (iq_due.size() != 0) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		wr_on = 1;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic send_item(input ciqs_in_t b, input logic lit, input ciqs_out_t want);
		ciqs_out_t got;
		if (wr_on) begin
			wr_en <= 1'b0;
			wr_on = 0;
		end
		push <= 1'b1;
		item <= b;
		push_on = 1;
		do @(posedge clk); while (full !== 1'b0);
		got = mix_sample(b);
		if (lit) begin
			got = want;
		end
		iq_due = {iq_due, got};
	endtask

	task automatic check_beat(input ciqs_out_t got);
		ciqs_out_t want;
		if (iq_due.size() == 0) begin
			$error("result beat with nothing expected");
			mismatches++;
		end else begin
			want = iq_due.pop_front();
			if (got.sample_i_out !== want.sample_i_out) begin
				$error("sample_i_out: expected %0d, got %0d", want.sample_i_out, got.sample_i_out);
				mismatches++;
			end
			if (got.sample_q_out !== want.sample_q_out) begin
				$error("sample_q_out: expected %0d, got %0d", want.sample_q_out, got.sample_q_out);
				mismatches++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
				mismatches++;
			end
		end
	endtask

	initial begin : result_side
		int hold_left;
		hold_left = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_beat(result);
			end
			if (stall_req) begin
				stall_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= steady || ($urandom_range(99) >= 15);
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		ciqs_cfg_t   setting;
		ciqs_in_t    b;
		logic [63:0] x;
		logic [63:0] mag;
		logic [63:0] a;
		logic [63:0] ph;
		logic [63:0] biased;
		logic [31:0] pm;
		longint      acc;
		longint      cs;
		arst_n   <= 1'b0;
		wr_en    <= 1'b0;
		wr_index <= '0;
		wr_data  <= '0;
		push     <= 1'b0;
		item     <= '0;

		cfg_now            = '0;
		cfg_now.pitch_gain = UNITY_GAIN;
		lo_acc             = '0;
		freq_acc           = '0;
		sig_acc            = '0;

		for (int i = 0; i < COS_DEPTH; i++) begin
			cos_tab[i] = turn_cos(32'((64'(i) << 32) / COS_DEPTH));
		end
		// j0 as the 64 point trapezoid mean of cos(x*|sin|)
		for (int k = 0; k < J0_DEPTH; k++) begin
			x   = (64'(k) << 31) / J0_DEPTH;
			acc = 0;
			for (int m = 0; m < 64; m++) begin
				pm  = (32'(m) << 26) - QTURN;
				cs  = turn_cos(pm);
				mag = (cs < 0) ? 64'(-cs) : 64'(cs);
				a   = (x * mag) >> 30;
				ph  = (a * TURN_PER_RAD) >> 26;
				acc = acc + turn_cos(ph[31:0]);
			end
			biased    = 64'(acc + 64 * UNIT_Q30);
			j0_tab[k] = longint'((biased + 64'd32) >> 6) - UNIT_Q30;
		end

		plan = '{
			known_row(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0),
			known_row(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0),
			known_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0),
			known_row(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0),
			known_row(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0),
			cfg_row(REG_AMPLITUDE_SCALE, 32'hFFFF_FFFF),
			beat_row(1'b1, 32'h7FFF_FFFF, 32'h0000_0000),
			beat_row(1'b0, 32'h8000_0000, 32'h8000_0000),
			cfg_row(REG_LO_PHASE_STEP, 32'h8000_0000),
			beat_row(1'b1, 32'h8000_0000, 32'h7FFF_FFFF),
			cfg_row(REG_CHIRP_STEP, 32'h8000_0000),
			cfg_row(REG_START_FREQ_STEP, 32'h0000_1000),
			beat_row(1'b1, 32'h0000_0000, 32'h0000_0000),
			beat_row(1'b0, 32'h1234_5678, 32'hEDCB_A988),
			cfg_row(REG_CHIRP_STEP, 32'h7FFF_FFFF),
			cfg_row(REG_START_FREQ_STEP, 32'hFFFF_FFFF),
			cfg_row(REG_PITCH_GAIN, 32'hFFFF_FFFF),
			cfg_row(REG_START_PHASE, 32'hFFFF_FFFF),
			cfg_row(REG_BESSEL_ARG_SCALE, 32'hFFFF_FFFF),
			cfg_row(REG_UNUSED, 32'hDEAD_BEEF),
			beat_row(1'b1, 32'h0000_0000, 32'h0000_0000),
			beat_row(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
			beat_row(1'b0, 32'h8000_0000, 32'h8000_0000),
			cfg_row(REG_BESSEL_ARG_SCALE, 32'h0100_0000),
			beat_row(1'b1, 32'h0000_0000, 32'h0000_0000),
			beat_row(1'b0, 32'h0000_0000, 32'h0000_0000)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].is_cfg) begin
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				send_item(plan[r].beat, plan[r].lit, plan[r].want);
				maybe_idle();
			end
		end

		for (int p = 0; p < RUN_PHASES; p++) begin
			case (p)
				1: begin
					setting.start_phase      = '1;
					setting.lo_phase_step    = '1;
					setting.start_freq_step  = '1;
					setting.chirp_step       = 32'h7FFF_FFFF;
					setting.pitch_gain       = '1;
					setting.amplitude_scale  = '1;
					setting.bessel_arg_scale = '1;
				end
				2: begin
					setting                 = '0;
					setting.chirp_step      = 32'h8000_0000;
					setting.amplitude_scale = '1;
				end
				default: begin
					setting.start_phase      = $urandom;
					setting.lo_phase_step    = pick_word();
					setting.start_freq_step  = pick_word();
					setting.chirp_step       = ($urandom_range(3) == 0) ? pick_word() :
						32'($urandom_range(0, 65535)) - 32'd32768;
					setting.pitch_gain       = $urandom_range(1) ?
						UNITY_GAIN + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19) : pick_word();
					setting.amplitude_scale  = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
					setting.bessel_arg_scale = pick_word();
				end
			endcase
			write_reg(REG_START_PHASE, setting.start_phase);
			write_reg(REG_LO_PHASE_STEP, setting.lo_phase_step);
			write_reg(REG_START_FREQ_STEP, setting.start_freq_step);
			write_reg(REG_CHIRP_STEP, setting.chirp_step);
			write_reg(REG_PITCH_GAIN, setting.pitch_gain);
			// junk in the upper half must be dropped
			write_reg(REG_AMPLITUDE_SCALE, {16'($urandom), setting.amplitude_scale});
			write_reg(REG_BESSEL_ARG_SCALE, setting.bessel_arg_scale);
			if ($urandom_range(1)) begin
				write_reg(REG_UNUSED, $urandom);
			end
			steady = (p == 4);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				b.start_req   = (n == 0) || ($urandom_range(39) == 0);
				b.sample_i_in = rand_level();
				b.sample_q_in = rand_level();
				send_item(b, 1'b0, '0);
				if (p == 2 && n == 40) begin
					stall_req = 1;
				end
				if (p == 3 && n == 80) begin
					drop_push();
					while (iq_due.size() != 0) @(posedge clk);
				end
				maybe_idle();
			end
		end
		steady = 0;

		drop_push();
		while (iq_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
